### src/dcps_pkg.sv
// Package for the discrete command port sequencer.
// Holds the command table, codes, channel widths and controller/datapath structs.
// No dependencies.
package dcps_pkg;

  localparam int NUM_PORTS_DEF    = 5;
  localparam int NUM_COMMANDS_DEF = 40;
  localparam int TABLE_SIZE       = 40;

  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 16;
  localparam int OUT_TUSER_W  = 3;

  localparam logic [2:0] STROBE_PORT = 3'd1;
  localparam logic [7:0] STROBE_BIT  = 8'h20;

  typedef enum logic [1:0] {
    K_INV    = 2'd0,
    K_SET    = 2'd1,
    K_STRB   = 2'd2,
    K_UNSTRB = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  // one port write per step; a strobe command walks all four
  typedef enum logic [1:0] {
    STEP_MERGE   = 2'd0,
    STEP_STRB_HI = 2'd1,
    STEP_STRB_LO = 2'd2,
    STEP_CLEAR   = 2'd3
  } step_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RUN  = 1'b1
  } state_e;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] port;
    logic [7:0] mask;
    logic [7:0] val;
  } entry_t;

  typedef struct packed {
    logic  load;   // capture the accepted request
    logic  fire;   // issue the result of the current step
    step_e step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
    logic last;      // current step gives the final result of the request
  } dp_sts_t;

  typedef struct packed {
    logic       is_write;
    logic [2:0] port_number;
    logic [7:0] port_byte;
    logic       hold_after;
    status_e    status;
    logic       last;
  } result_t;

  localparam entry_t CMD_TABLE [TABLE_SIZE] = '{
    '{K_STRB, 3'd0, 8'h01, 8'h01}, '{K_STRB, 3'd0, 8'h02, 8'h02},
    '{K_STRB, 3'd0, 8'h04, 8'h04}, '{K_STRB, 3'd0, 8'h08, 8'h08},
    '{K_STRB, 3'd0, 8'h10, 8'h10}, '{K_STRB, 3'd0, 8'h20, 8'h20},
    '{K_STRB, 3'd0, 8'h40, 8'h40}, '{K_SET,  3'd0, 8'h80, 8'h80},
    '{K_SET,  3'd1, 8'h01, 8'h01}, '{K_SET,  3'd1, 8'h02, 8'h02},
    '{K_STRB, 3'd1, 8'h04, 8'h04}, '{K_STRB, 3'd1, 8'h08, 8'h08},
    '{K_STRB, 3'd1, 8'h10, 8'h10}, '{K_INV,  3'd1, 8'h20, 8'h20},
    '{K_SET,  3'd1, 8'h40, 8'h40}, '{K_SET,  3'd1, 8'h80, 8'h80},
    '{K_SET,  3'd2, 8'h01, 8'h01}, '{K_SET,  3'd2, 8'h02, 8'h02},
    '{K_SET,  3'd2, 8'h04, 8'h04}, '{K_SET,  3'd2, 8'h08, 8'h08},
    '{K_SET,  3'd2, 8'h10, 8'h10}, '{K_INV,  3'd2, 8'h20, 8'h20},
    '{K_INV,  3'd2, 8'h40, 8'h40}, '{K_SET,  3'd2, 8'h80, 8'h80},
    '{K_INV,  3'd3, 8'h01, 8'h01}, '{K_INV,  3'd3, 8'h02, 8'h02},
    '{K_INV,  3'd3, 8'h04, 8'h04}, '{K_INV,  3'd3, 8'h08, 8'h08},
    '{K_INV,  3'd3, 8'h10, 8'h10}, '{K_INV,  3'd3, 8'h20, 8'h20},
    '{K_INV,  3'd3, 8'h40, 8'h40}, '{K_INV,  3'd3, 8'h80, 8'h80},
    '{K_SET,  3'd4, 8'h01, 8'h01}, '{K_SET,  3'd4, 8'h02, 8'h02},
    '{K_SET,  3'd4, 8'h04, 8'h04}, '{K_SET,  3'd4, 8'h08, 8'h08},
    '{K_SET,  3'd4, 8'h10, 8'h10}, '{K_SET,  3'd4, 8'h20, 8'h20},
    '{K_SET,  3'd4, 8'h40, 8'h40}, '{K_SET,  3'd4, 8'h80, 8'h80}
  };

  // indexes beyond the table are screened out before the entry is used
  function automatic entry_t lookup(input logic [5:0] idx);
    entry_t e;
    e = CMD_TABLE[0];
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (idx == 6'(i)) begin
        e = CMD_TABLE[i];
      end
    end
    return e;
  endfunction

endpackage

### src/dcps_ctrl.sv
// Controller for the discrete command port sequencer.
// Accepts one request, then steps the datapath through its port writes.
// Depends on dcps_pkg.
module dcps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  dcps_pkg::dp_sts_t   sts_i,
  output dcps_pkg::ctrl_cmd_t cmd_o
);
  import dcps_pkg::*;

  state_e state_q, state_d;
  step_e  step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= STEP_MERGE;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    s_axis_tready = 1'b0;
    cmd_o         = '{load: 1'b0, fire: 1'b0, step: step_q};
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          step_d     = STEP_MERGE;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        if (sts_i.out_free) begin
          cmd_o.fire = 1'b1;
          if (sts_i.last) begin
            state_d = S_IDLE;
          end else begin
            step_d = step_e'(2'(step_q + 2'd1));
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### src/dcps_dp.sv
// Datapath for the discrete command port sequencer.
// Request registers, table decode, port shadow registers, merge logic, output register.
// Depends on dcps_pkg.
module dcps_dp #(
  parameter int NumPorts    = dcps_pkg::NUM_PORTS_DEF,
  parameter int NumCommands = dcps_pkg::NUM_COMMANDS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                command_i,
  input  logic [5:0]          target_index_i,
  input  logic [7:0]          data_value_i,
  input  dcps_pkg::ctrl_cmd_t cmd_i,
  output dcps_pkg::dp_sts_t   sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dcps_pkg::result_t   res_o
);
  import dcps_pkg::*;

  localparam logic [6:0] PortsLim = 7'(NumPorts);
  localparam logic [6:0] CmdsLim  = 7'(NumCommands);
  localparam logic [6:0] TblLim   = 7'(TABLE_SIZE);
  localparam logic [3:0] PortsLim4 = 4'(NumPorts);

  logic       command_q;
  logic [5:0] index_q;
  logic [7:0] data_q;

  logic [7:0] shadow_q [NumPorts];

  entry_t     entry;
  status_e    err;
  logic [2:0] tgt_port;
  logic [7:0] rd_tgt;
  logic [7:0] rd_strb;
  logic [7:0] src;
  result_t    res;
  logic       sh_we;

  logic    out_valid_q;
  result_t res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      command_q <= command_i;
      index_q   <= target_index_i;
      data_q    <= data_value_i;
    end
  end

  always_comb begin
    entry = lookup(index_q);
    if (command_q) begin
      err = ({1'b0, index_q} >= PortsLim) ? ST_RANGE : ST_OK;
    end else if ({1'b0, index_q} >= CmdsLim) begin
      err = ST_RANGE;
    end else if ({1'b0, index_q} >= TblLim) begin
      err = ST_INVALID;
    end else if ({1'b0, entry.port} >= PortsLim4 || entry.kind == K_INV) begin
      err = ST_INVALID;
    end else begin
      err = ST_OK;
    end
  end

  assign tgt_port = command_q ? index_q[2:0] : entry.port;
  assign rd_strb  = shadow_q[STROBE_PORT];
  assign src      = (entry.kind == K_SET) ? data_q : entry.val;

  always_comb begin
    rd_tgt = '0;
    for (int i = 0; i < NumPorts; i++) begin
      if (tgt_port == 3'(i)) begin
        rd_tgt = shadow_q[i];
      end
    end
  end

  always_comb begin
    res = '{is_write: 1'b1, port_number: tgt_port, port_byte: 8'h00,
            hold_after: 1'b0, status: ST_OK, last: 1'b1};
    sh_we = 1'b0;
    case (cmd_i.step)
      STEP_MERGE: begin
        sh_we = 1'b1;
        if (command_q) begin
          res.port_byte = data_q;
        end else begin
          res.port_byte = (rd_tgt & ~entry.mask) | (src & entry.mask);
          res.last      = (entry.kind != K_STRB);
        end
      end
      STEP_STRB_HI: begin
        res.port_number = STROBE_PORT;
        res.port_byte   = rd_strb | STROBE_BIT;
        res.hold_after  = 1'b1;
        res.last        = 1'b0;
      end
      STEP_STRB_LO: begin
        res.port_number = STROBE_PORT;
        res.port_byte   = rd_strb;
        res.hold_after  = 1'b1;
        res.last        = 1'b0;
      end
      STEP_CLEAR: begin
        sh_we         = 1'b1;
        res.port_byte = rd_tgt & ~entry.mask;
      end
      default: begin
        res.last = 1'b1;
      end
    endcase
    if (err != ST_OK) begin
      res   = '{is_write: 1'b0, port_number: 3'd0, port_byte: 8'h00,
                hold_after: 1'b0, status: err, last: 1'b1};
      sh_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPorts; i++) begin
        shadow_q[i] <= '0;
      end
    end else if (cmd_i.fire && sh_we) begin
      for (int i = 0; i < NumPorts; i++) begin
        if (tgt_port == 3'(i)) begin
          shadow_q[i] <= res.port_byte;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fire) begin
      res_q <= res;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.last     = res.last;
  assign out_valid_o    = out_valid_q;
  assign res_o          = res_q;

endmodule

### src/discrete_command_port_sequencer_unit.sv
// Top level of the discrete command port sequencer.
// Instantiates dcps_ctrl and dcps_dp; depends on dcps_pkg.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------------
//  s_axis  | in  | s_axis_tvalid/tready   | tuser: command; tdata: index, data
//  m_axis  | out | m_axis_tvalid/tready   | tuser: is_write, status; tdata: port,
//          |     |                        | byte, hold; tlast: last
//
// A request is captured first and then gives one result, or four for a strobe command:
// one port write per cycle while the output register can take it, set by the sequencer stepping
// the shadow reads and the merge path. The next request is taken while the final result
// still sits in the output register. Reset clears the NumPorts (default five) shadow registers at once.
// A low m_axis_tready with a full output register stalls the sequencer on its current step.
module discrete_command_port_sequencer_unit #(
  parameter int NumPorts    = dcps_pkg::NUM_PORTS_DEF,
  parameter int NumCommands = dcps_pkg::NUM_COMMANDS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [dcps_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [5:0] target_index,
                                                              // [13:6] data_value
  input  logic                                 s_axis_tuser,  // [0] command
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [dcps_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [2:0] port_number,
                                                              // [10:3] port_byte,
                                                              // [11] hold_after
  output logic [dcps_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,  // [0] is_write,
                                                              // [2:1] status
  output logic                                 m_axis_tlast
);
  import dcps_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;
  result_t   res;

  dcps_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (dp_sts),
    .cmd_o         (ctrl_cmd)
  );

  dcps_dp #(
    .NumPorts    (NumPorts),
    .NumCommands (NumCommands)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .command_i      (s_axis_tuser),
    .target_index_i (s_axis_tdata[5:0]),
    .data_value_i   (s_axis_tdata[13:6]),
    .cmd_i          (ctrl_cmd),
    .sts_o          (dp_sts),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .res_o          (res)
  );

  assign m_axis_tdata = {4'b0000, res.hold_after, res.port_byte, res.port_number};
  assign m_axis_tuser = {res.status, res.is_write};
  assign m_axis_tlast = res.last;

  // an error result carries nothing but its status and ends the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == '0)
    else $error("error result with payload or without tlast");

  // strobe writes with hold always go to the strobe port and never end a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tdata[2:0] == STROBE_PORT && !m_axis_tlast)
    else $error("hold write off the strobe port");

  // a captured request keeps the sequencer busy in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while sequencer busy");

  // a successful result is a write, a failed one is not
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[0] == (m_axis_tuser[2:1] == ST_OK))
    else $error("is_write disagrees with status");

endmodule
